FILE: rtl/cle_pkg.sv
// Shared constants, types and codes for the console line editor.
package cle_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int COUNT_W    = 5;
  localparam int SIZE_W     = 6;
  localparam int SIZE_TOP   = (LINE_DEPTH < 32) ? LINE_DEPTH : 32;
  localparam int MAX_RESULTS = 32;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(SIZE_TOP);

  // Readout cap after a three-byte erase echo
  localparam logic [COUNT_W-1:0] ERASE_CAP = COUNT_W'(MAX_RESULTS - 3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_LOAD,
    ST_EMIT
  } state_t;

  // Line buffer access for one cycle
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } buf_req_t;

endpackage

FILE: rtl/cle_line_buf.sv
// Line buffer memory: one write port, one registered read port.
module cle_line_buf
  import cle_pkg::*;
(
  input  logic       clk,
  input  buf_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [LINE_DEPTH];

  // Write the stored byte
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read and hold the byte until the next enabled read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: rtl/console_line_editor.sv
// Top level of the console line editor: sequencer, count, output register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   in      | input     | in_valid/in_stall  | rx_byte
//   out     | output    | out_valid/out_stall| result_kind, data_byte, line_length, last
//   cfg     | input     | cfg_valid/cfg_ready| line_size
//
// An accepted byte is decoded and its echo bytes (up to three) are sent; when the
// line completes, the buffer is prefetched (ST_LOAD) and each stored byte is read
// out in turn through the single buffer read port.
// in_stall is high while a byte is still being worked on.
// Reset (rst, synchronous) clears the count, sequencer and output valid and
// sets line_size to 32; buffer contents are not cleared.
// With out_valid high, out_stall only holds the output register and echo/readout.
module console_line_editor
  import cle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              result_kind,
  output logic [7:0]        data_byte,
  output logic [4:0]        line_length,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] line_size
);

  state_t             state, state_next;
  logic [SIZE_W-1:0]  size_reg;
  logic [COUNT_W-1:0] count;
  logic [7:0]         cbyte;
  logic               erase;
  logic [1:0]         echo_cnt;
  logic [1:0]         echo_idx;
  logic               complete;
  logic [COUNT_W-1:0] line_len;
  logic [COUNT_W-1:0] rd_cap;
  logic [COUNT_W-1:0] rd_idx;

  logic               accept;
  logic               slot_free;
  logic [7:0]         c_in;
  logic               in_erase;
  logic               in_ignore;
  logic [COUNT_W-1:0] new_count;
  logic [SIZE_W-1:0]  eff_size;
  logic [COUNT_W-1:0] limit;
  logic               in_complete;
  logic [1:0]         in_echo_cnt;
  logic               echo_end;
  logic               emit_end;

  logic               out_load;
  logic               load_kind;
  logic [7:0]         load_data;
  logic [4:0]         load_len;
  logic               load_last;

  buf_req_t           breq;
  logic [7:0]         buf_q;

  cle_line_buf u_buf (
    .clk     (clk),
    .req     (breq),
    .rd_data (buf_q)
  );

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= line_size;
    end
  end

  // Clamp the size and form the stored-byte limit
  always_comb begin
    if (size_reg < SIZE_MIN) begin
      eff_size = SIZE_MIN;
    end else if (size_reg > SIZE_MAX) begin
      eff_size = SIZE_MAX;
    end else begin
      eff_size = size_reg;
    end
    limit = COUNT_W'(eff_size - SIZE_W'(1));
  end

  // Decode the incoming byte
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    c_in        = (rx_byte == CH_CR) ? CH_LF : rx_byte;
    in_erase    = (c_in == CH_BS) || (c_in == CH_DEL);
    in_ignore   = in_erase && (count == '0);
    new_count   = in_erase ? (count - COUNT_W'(1)) : (count + COUNT_W'(1));
    in_complete = ((c_in == CH_LF) || (new_count >= limit)) && (new_count != '0);
    if (in_erase) begin
      in_echo_cnt = 2'd3;
    end else if (c_in == CH_LF) begin
      in_echo_cnt = 2'd0;
    end else begin
      in_echo_cnt = 2'd1;
    end
  end

  assign echo_end = (echo_idx == (echo_cnt - 2'd1));
  assign emit_end = (rd_idx == (rd_cap - COUNT_W'(1)));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !in_ignore) begin
          if (in_echo_cnt != 2'd0) begin
            state_next = ST_ECHO;
          end else if (in_complete) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_ECHO: begin
        if (slot_free && echo_end) begin
          state_next = complete ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && emit_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    out_load     = 1'b0;
    load_kind    = KIND_ECHO;
    load_data    = cbyte;
    load_len     = '0;
    load_last    = 1'b0;
    breq.wr_en   = 1'b0;
    breq.wr_addr = ADDR_W'(count);
    breq.wr_data = c_in;
    breq.rd_en   = 1'b0;
    breq.rd_addr = ADDR_W'(rd_idx + COUNT_W'(1));
    case (state)
      ST_IDLE: begin
        breq.wr_en = accept && !in_erase;
      end
      ST_ECHO: begin
        out_load  = slot_free;
        load_kind = KIND_ECHO;
        if (erase) begin
          load_data = (echo_idx == 2'd1) ? CH_SPACE : CH_BS;
        end else begin
          load_data = cbyte;
        end
        load_last = echo_end && !complete;
      end
      ST_LOAD: begin
        breq.rd_en   = 1'b1;
        breq.rd_addr = '0;
      end
      ST_EMIT: begin
        out_load   = slot_free;
        load_kind  = KIND_LINE;
        load_data  = buf_q;
        load_len   = line_len;
        load_last  = emit_end;
        breq.rd_en = slot_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Sequencer and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && !in_ignore) begin
        count <= in_complete ? '0 : new_count;
      end
    end
  end

  // Latch the per-byte work and advance the echo and readout indexes
  always_ff @(posedge clk) begin
    if (accept) begin
      cbyte    <= c_in;
      erase    <= in_erase;
      echo_cnt <= in_echo_cnt;
      echo_idx <= 2'd0;
      complete <= in_complete;
      line_len <= new_count;
      rd_cap   <= (in_erase && (new_count > ERASE_CAP)) ? ERASE_CAP : new_count;
    end else if (state == ST_ECHO && slot_free) begin
      echo_idx <= echo_idx + 2'd1;
    end
    if (state == ST_LOAD) begin
      rd_idx <= '0;
    end else if (state == ST_EMIT && slot_free) begin
      rd_idx <= rd_idx + COUNT_W'(1);
    end
  end

  // Output register: load on transfer slot, drop valid when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind <= load_kind;
      data_byte   <= load_data;
      line_length <= load_len;
      last        <= load_last;
    end
  end

endmodule
